@@ hdl/mvam_pkg.sv @@
// Shared types and constants of the multi-voice audio mixer.
package mvam_pkg;

   // Opcodes of an input item, echoed in the kind field of its result.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_MIX   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // Longest sound a voice can hold; longer requests are clipped to it.
   localparam logic [16:0] MAX_LEN = 17'd65536;

   // Configuration port: a single register, read as a 32-bit word anywhere in the address range.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // Byte address of the mute register.
   localparam logic [CSR_ADDR_W-1:0] CSR_MUTE_ADDR = '0;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [15:0]        address;
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
      logic [16:0]        sound_length;
      logic [15:0]        gain;
      logic               loop_request;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] mix_left;
      logic signed [15:0] mix_right;
      logic [2:0]         voice_taken;
      logic               start_ok;
   } rsp_type;

   // Control of the shared multiply and saturating accumulate unit.
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic add_left;
      logic add_right;
   } mac_ctrl_type;

endpackage

@@ hdl/multi_voice_audio_mixer.sv @@
// Top level of the saturating multi-voice stereo PCM mixer.
//
// Three kinds of item share one input channel: a sample write stores a stereo
// word (left in the low half) at address modulo SAMPLE_WORDS; a start claims
// the lowest idle voice for a sound at base, length, gain and loop flag; a
// mix tick returns one saturated stereo frame and advances every active
// voice. Every item, also one with opcode OP_NONE, gives exactly one result
// transfer. The block handles one item at a time under a small sequencer and
// holds req_stall high while it works. A write or start first reduces the
// address in M compare and subtract steps (M = 0 when SAMPLE_WORDS > 65535,
// else clog2(65535/SAMPLE_WORDS + 1)); a start then scans the voices from the
// lowest index; a tick visits each voice in turn, and the single shared
// multiplier serves left then right of each active voice. Reads of the voice
// and sample memories are registered. A finished result waits in an output
// register, so the last cycle of an item is only held back while that
// register still holds an untaken result. The mute register (byte address 0,
// bit 0) zeroes the frames while voices keep advancing; write it only while
// idle.
module multi_voice_audio_mixer #(
   parameter int VOICE_COUNT  = 8,
   parameter int SAMPLE_WORDS = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mvam_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mvam_pkg::rsp_type             rsp_payload,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mvam_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mvam_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mvam_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import mvam_pkg::*;

   localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int AW = $clog2(SAMPLE_WORDS);
   // restoring reduction of a 16-bit address modulo SAMPLE_WORDS
   localparam int MOD_STEPS = (SAMPLE_WORDS > 65535) ? 0
                              : $clog2(65535 / SAMPLE_WORDS + 1);
   localparam int SW = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
   localparam int MOD_TOP = (MOD_STEPS > 0) ? MOD_STEPS - 1 : 0;

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MOD       = 4'd1;
   localparam logic [3:0] ST_WRITE     = 4'd2;
   localparam logic [3:0] ST_SCAN      = 4'd3;
   localparam logic [3:0] ST_MIX_CHK   = 4'd4;
   localparam logic [3:0] ST_MIX_FETCH = 4'd5;
   localparam logic [3:0] ST_MIX_LEFT  = 4'd6;
   localparam logic [3:0] ST_MIX_RIGHT = 4'd7;
   localparam logic [3:0] ST_MIX_ACC   = 4'd8;
   localparam logic [3:0] ST_MIX_END   = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   // One voice entry. rd_addr tracks (base + position) mod SAMPLE_WORDS so a
   // tick never divides; base_mod is what it returns to on a wrap.
   typedef struct packed {
      logic          loops;
      logic [AW-1:0] base_mod;
      logic [16:0]   length;
      logic [15:0]   gain;
      logic [15:0]   position;
      logic [AW-1:0] rd_addr;
   } voice_type;

   logic [3:0]             state_ff, state_in;
   req_type                req_ff, req_in;
   rsp_type                res_ff, res_in;
   logic [15:0]            rem_ff, rem_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [VW-1:0]          voice_ff, voice_in;
   logic [VOICE_COUNT-1:0] active_ff, active_in;
   logic                   mute_ff, mute_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_payload_ff, rsp_payload_in;

   // memories, registered read data
   logic [31:0]            sample_mem [SAMPLE_WORDS];
   logic [31:0]            sample_rd_ff;
   voice_type              voice_mem [VOICE_COUNT];
   voice_type              voice_rd_ff;

   logic                   sample_we;
   logic                   voice_we;
   voice_type              voice_wd;

   logic [31:0]            divisor;
   logic [16:0]            len_sat;
   logic [16:0]            next_pos;
   logic [AW:0]            ra_inc;
   logic [AW-1:0]          ra_next;
   logic                   last_voice;
   logic                   csr_write;

   mac_ctrl_type           mac_ctrl;
   logic signed [15:0]     mac_sample;
   logic signed [15:0]     acc_left;
   logic signed [15:0]     acc_right;

   mvam_mac u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .sample    (mac_sample),
      .gain      (voice_rd_ff.gain),
      .acc_left  (acc_left),
      .acc_right (acc_right)
   );

   // ---------------------------------------------------------------- csr
   // Mute register decoded at its byte address; reads return it anywhere.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = {{(CSR_DATA_W-1){1'b0}}, mute_ff};

   always_comb begin
      mute_in = mute_ff;
      if (csr_write && (paddr == CSR_MUTE_ADDR)) begin
         mute_in = pwdata[0];
      end
   end

   // ------------------------------------------------------------ helpers
   assign divisor    = 32'(SAMPLE_WORDS) << step_ff;
   assign len_sat    = (req_ff.sound_length > MAX_LEN) ? MAX_LEN : req_ff.sound_length;
   assign next_pos   = {1'b0, voice_rd_ff.position} + 17'd1;
   assign ra_inc     = {1'b0, voice_rd_ff.rd_addr} + (AW+1)'(1);
   assign ra_next    = (ra_inc == (AW+1)'(SAMPLE_WORDS)) ? '0 : ra_inc[AW-1:0];
   assign last_voice = (voice_ff == VW'(VOICE_COUNT - 1));

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      voice_in       = voice_ff;
      active_in      = active_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      sample_we      = 1'b0;
      voice_we       = 1'b0;
      voice_wd       = voice_rd_ff;
      mac_ctrl       = '0;
      mac_sample     = sample_rd_ff[15:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_payload;
               res_in      = '0;
               res_in.kind = req_payload.opcode;
               rem_in      = req_payload.address;
               step_in     = SW'(MOD_TOP);
               voice_in    = '0;
               case (req_payload.opcode)
                  OP_WRITE: begin
                     state_in = (MOD_STEPS == 0) ? ST_WRITE : ST_MOD;
                  end
                  OP_START: begin
                     state_in = (MOD_STEPS == 0) ? ST_SCAN : ST_MOD;
                  end
                  OP_MIX: begin
                     mac_ctrl.clear = 1'b1;
                     state_in       = ST_MIX_CHK;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // one compare and subtract of the address reduction per cycle
         ST_MOD: begin
            if ({16'b0, rem_ff} >= divisor) begin
               rem_in = rem_ff - divisor[15:0];
            end
            if (step_ff == '0) begin
               state_in = (req_ff.opcode == OP_WRITE) ? ST_WRITE : ST_SCAN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end

         ST_WRITE: begin
            sample_we = 1'b1;
            state_in  = ST_DONE;
         end

         // lowest idle voice, one voice per cycle
         ST_SCAN: begin
            if (!active_ff[voice_ff]) begin
               voice_we            = 1'b1;
               voice_wd.loops      = req_ff.loop_request;
               voice_wd.base_mod   = AW'(rem_ff);
               voice_wd.length     = len_sat;
               voice_wd.gain       = req_ff.gain;
               voice_wd.position   = '0;
               voice_wd.rd_addr    = AW'(rem_ff);
               active_in[voice_ff] = 1'b1;
               res_in.start_ok     = 1'b1;
               res_in.voice_taken  = 3'(voice_ff);
               state_in            = ST_DONE;
            end else if (last_voice) begin
               state_in = ST_DONE;
            end else begin
               voice_in = voice_ff + VW'(1);
            end
         end

         ST_MIX_CHK: begin
            if (active_ff[voice_ff]) begin
               state_in = ST_MIX_FETCH;
            end else if (last_voice) begin
               state_in = ST_MIX_END;
            end else begin
               voice_in = voice_ff + VW'(1);
            end
         end

         // voice entry is here; sample read issues; advance the voice
         ST_MIX_FETCH: begin
            voice_we = 1'b1;
            if (next_pos >= voice_rd_ff.length) begin
               voice_wd.position = '0;
               voice_wd.rd_addr  = voice_rd_ff.base_mod;
               if (!voice_rd_ff.loops) begin
                  active_in[voice_ff] = 1'b0;
               end
            end else begin
               voice_wd.position = next_pos[15:0];
               voice_wd.rd_addr  = ra_next;
            end
            state_in = ST_MIX_LEFT;
         end

         ST_MIX_LEFT: begin
            mac_ctrl.mul_en = 1'b1;
            mac_sample      = sample_rd_ff[15:0];
            state_in        = ST_MIX_RIGHT;
         end

         ST_MIX_RIGHT: begin
            mac_ctrl.add_left = 1'b1;
            mac_ctrl.mul_en   = 1'b1;
            mac_sample        = sample_rd_ff[31:16];
            state_in          = ST_MIX_ACC;
         end

         ST_MIX_ACC: begin
            mac_ctrl.add_right = 1'b1;
            if (last_voice) begin
               state_in = ST_MIX_END;
            end else begin
               voice_in = voice_ff + VW'(1);
               state_in = ST_MIX_CHK;
            end
         end

         ST_MIX_END: begin
            if (!mute_ff) begin
               res_in.mix_left  = acc_left;
               res_in.mix_right = acc_right;
            end
            state_in = ST_DONE;
         end

         // hand the result over once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in = res_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         mute_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         mute_ff      <= mute_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      res_ff         <= res_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      voice_ff       <= voice_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (sample_we) begin
         sample_mem[AW'(rem_ff)] <= {req_ff.right_in, req_ff.left_in};
      end
      sample_rd_ff <= sample_mem[voice_rd_ff.rd_addr];
   end

   // voice table: written and read at the current voice index
   always_ff @(posedge clock) begin
      if (voice_we) begin
         voice_mem[voice_ff] <= voice_wd;
      end
      voice_rd_ff <= voice_mem[voice_ff];
   end

endmodule

@@ hdl/mvam_mac.sv @@
// Shared multiply and saturating accumulate unit for the mixer channels.
module mvam_mac (
   input  logic                 clock,
   input  mvam_pkg::mac_ctrl_type ctrl,
   input  logic signed [15:0]   sample,
   input  logic [15:0]          gain,
   output logic signed [15:0]   acc_left,
   output logic signed [15:0]   acc_right
);
   import mvam_pkg::*;

   logic signed [32:0] sample_x;
   logic signed [32:0] gain_x;
   logic signed [32:0] product_ff;
   logic signed [32:0] product_in;
   logic signed [16:0] scaled;
   logic signed [15:0] acc_sel;
   logic signed [17:0] sum;
   logic signed [15:0] sat_sum;
   logic signed [15:0] acc_left_ff;
   logic signed [15:0] acc_left_in;
   logic signed [15:0] acc_right_ff;
   logic signed [15:0] acc_right_in;

   assign sample_x   = {{17{sample[15]}}, sample};
   assign gain_x     = {17'b0, gain};
   assign product_in = sample_x * gain_x;

   // divide by 65536, truncating toward zero
   assign scaled = product_ff[32:16]
                   + {16'b0, (product_ff[32] && (product_ff[15:0] != 16'b0))};

   assign acc_sel = ctrl.add_right ? acc_right_ff : acc_left_ff;
   assign sum     = {{2{acc_sel[15]}}, acc_sel} + {scaled[16], scaled};

   always_comb begin
      if (sum > 18'sd32767) begin
         sat_sum = 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         sat_sum = 16'sh8000;
      end else begin
         sat_sum = sum[15:0];
      end
   end

   always_comb begin
      acc_left_in  = acc_left_ff;
      acc_right_in = acc_right_ff;
      if (ctrl.clear) begin
         acc_left_in  = '0;
         acc_right_in = '0;
      end else if (ctrl.add_right) begin
         acc_right_in = sat_sum;
      end else if (ctrl.add_left) begin
         acc_left_in = sat_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         product_ff <= product_in;
      end
      acc_left_ff  <= acc_left_in;
      acc_right_ff <= acc_right_in;
   end

   assign acc_left  = acc_left_ff;
   assign acc_right = acc_right_ff;

endmodule

@@ hdl/mvam_checker.sv @@
// Port-level assertions for the mixer, bound to its top level.
module mvam_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mvam_pkg::rsp_type rsp_payload
);
   import mvam_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // one item at a time: busy straight after a transfer in
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous item in progress");

   a_start_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != OP_START)
      |-> !rsp_payload.start_ok && (rsp_payload.voice_taken == 3'd0))
      else $error("start fields set on a non-start result");

   a_mix_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != OP_MIX)
      |-> (rsp_payload.mix_left == 16'sd0) && (rsp_payload.mix_right == 16'sd0))
      else $error("frame fields set on a non-tick result");

endmodule

bind multi_voice_audio_mixer mvam_checker u_mvam_checker (.*);
